### src/pab_pkg.sv
// shared widths, stage payload types and the rounded 8x8 product divided by 255 for the alpha blender
// no dependencies
`timescale 1ns / 1ps

package pab_pkg;

   localparam int PIX_W               = 8;
   localparam int CHANNELS            = 3;
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES          = PIX_W / DIV_STEPS_PER_STAGE;
   localparam logic [PIX_W-1:0] ALPHA_FULL = {PIX_W{1'b1}};
   localparam logic [15:0]      ROUND_BIAS = 16'd128;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [CHANNELS-1:0] rgb_type;

   typedef struct packed {
      rgb_type src;
      rgb_type dst;
      pix_type da;
      pix_type ea;
      logic    ga_zero;
   } s1_type;

   typedef struct packed {
      logic    blend;
      rgb_type byp_rgb;
      pix_type byp_alpha;
      rgb_type sp;
      rgb_type dd;
      pix_type inv;
      pix_type na;
   } s2_type;

   typedef struct packed {
      logic    blend;
      rgb_type byp_rgb;
      pix_type byp_alpha;
      rgb_type v;
      pix_type na;
   } s3_type;

   typedef struct packed {
      logic    blend;
      rgb_type byp_rgb;
      pix_type byp_alpha;
      pix_type na;
      rgb_type rem;
      rgb_type low;
      rgb_type quo;
   } div_type;

   // round(a * b / 255)
   function automatic pix_type mdiv255(input pix_type a, input pix_type b);
      logic [15:0] t;
      logic [15:0] s;
      t = {8'h00, a} * {8'h00, b} + ROUND_BIAS;
      s = {8'h00, t[15:8]} + t;
      return s[15:8];
   endfunction

endpackage

### src/pab_if.sv
// request and response channel interfaces of the alpha blender
// depends on pab_pkg
`timescale 1ns / 1ps

interface pab_req_if;
   import pab_pkg::*;
   logic    valid;
   logic    ready;
   pix_type src_red;
   pix_type src_green;
   pix_type src_blue;
   pix_type mask_alpha;
   pix_type dst_red;
   pix_type dst_green;
   pix_type dst_blue;
   pix_type dst_alpha;

   modport source (output valid, src_red, src_green, src_blue, mask_alpha,
                   dst_red, dst_green, dst_blue, dst_alpha, input ready);
   modport sink (input valid, src_red, src_green, src_blue, mask_alpha,
                 dst_red, dst_green, dst_blue, dst_alpha, output ready);
endinterface

interface pab_rsp_if;
   import pab_pkg::*;
   logic    valid;
   logic    ready;
   pix_type out_red;
   pix_type out_green;
   pix_type out_blue;
   pix_type out_alpha;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

### src/pixel_alpha_over_blend.sv
// straight-alpha over blend of a source rgb pixel onto a destination rgba pixel
// depends on pab_pkg and the channel interfaces in pab_if.sv
//
// usage:
//   req_bus carries one source pixel, its mask alpha and the destination pixel
//   per transaction; rsp_bus returns the blended destination pixel, one
//   transaction out for every transaction in, in the same order.
//   csr_we / csr_wdata write the global alpha (reset value 255); write it only
//   while no transaction is in flight.
// structure: eight register stages between request acceptance and the response.
// throughput: one pixel per cycle while the response side is not stalled; every
//   stage is a register slice, and the final divide by the new alpha retires two
//   quotient bits per stage over four stages.
// reset: synchronous, clears all stage valid bits and sets global alpha to 255.
// stall: each stage keeps its own valid bit and takes new data whenever it is
//   empty or its successor moves, so a stalled receiver only backs up the
//   stages behind a full one and bubbles are squeezed out.
`timescale 1ns / 1ps

module pixel_alpha_over_blend (
   input  logic           clock,
   input  logic           reset,
   pab_req_if.sink        req_bus,
   pab_rsp_if.source      rsp_bus,
   input  logic           csr_we,
   input  pab_pkg::pix_type csr_wdata
);
   import pab_pkg::*;

   localparam int NUM_STAGES = 4 + DIV_STAGES;

   pix_type ga_ff;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] stage_ready;
   logic [NUM_STAGES-1:0] valid_prev;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   div_type div_ff [DIV_STAGES+1];
   div_type div_in [DIV_STAGES+1];

   function automatic div_type div_advance(input div_type x);
      div_type     y;
      logic [8:0]  r9;
      logic        qb;
      y = x;
      for (int st = 0; st < DIV_STEPS_PER_STAGE; st++) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            r9 = {y.rem[ch], y.low[ch][PIX_W-1]};
            y.low[ch] = {y.low[ch][PIX_W-2:0], 1'b0};
            qb = 1'b0;
            if (r9 >= {1'b0, y.na}) begin
               r9 = r9 - {1'b0, y.na};
               qb = 1'b1;
            end
            y.rem[ch] = r9[PIX_W-1:0];
            y.quo[ch] = {y.quo[ch][PIX_W-2:0], qb};
         end
      end
      return y;
   endfunction

   // handshake chain
   always_comb begin
      stage_ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_bus.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_prev = {valid_ff[NUM_STAGES-2:0], req_bus.valid};
   end

   assign req_bus.ready = stage_ready[0];

   // stage 1: effective alpha
   always_comb begin
      s1_in.src     = '{req_bus.src_blue, req_bus.src_green, req_bus.src_red};
      s1_in.dst     = '{req_bus.dst_blue, req_bus.dst_green, req_bus.dst_red};
      s1_in.da      = req_bus.dst_alpha;
      s1_in.ga_zero = (ga_ff == '0);
      if (ga_ff != ALPHA_FULL && req_bus.mask_alpha != '0) begin
         s1_in.ea = mdiv255(req_bus.mask_alpha, ga_ff);
      end else begin
         s1_in.ea = req_bus.mask_alpha;
      end
   end

   // stage 2: case select, new alpha and first products
   always_comb begin
      pix_type inv;
      pix_type na;
      inv = ALPHA_FULL - s1_ff.ea;
      na  = s1_ff.ea + mdiv255(s1_ff.da, inv);
      s2_in.inv = inv;
      s2_in.na  = (na == '0) ? pix_type'(1) : na;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s2_in.sp[ch] = mdiv255(s1_ff.src[ch], s1_ff.ea);
         s2_in.dd[ch] = mdiv255(s1_ff.dst[ch], s1_ff.da);
      end
      s2_in.blend     = 1'b0;
      s2_in.byp_rgb   = s1_ff.dst;
      s2_in.byp_alpha = s1_ff.da;
      priority if (s1_ff.ga_zero) begin
         s2_in.blend = 1'b0;
      end else if (s1_ff.ea == ALPHA_FULL || s1_ff.da == '0) begin
         s2_in.byp_rgb   = s1_ff.src;
         s2_in.byp_alpha = s1_ff.ea;
      end else if (s1_ff.ea != '0) begin
         s2_in.blend = 1'b1;
      end else begin
         s2_in.blend = 1'b0;
      end
   end

   // stage 3: blended numerators
   always_comb begin
      s3_in.blend     = s2_ff.blend;
      s3_in.byp_rgb   = s2_ff.byp_rgb;
      s3_in.byp_alpha = s2_ff.byp_alpha;
      s3_in.na        = s2_ff.na;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s3_in.v[ch] = s2_ff.sp[ch] + mdiv255(s2_ff.dd[ch], s2_ff.inv);
      end
   end

   // divider entry and iterations
   always_comb begin
      logic [15:0] num;
      div_in[0].blend     = s3_ff.blend;
      div_in[0].byp_rgb   = s3_ff.byp_rgb;
      div_in[0].byp_alpha = s3_ff.byp_alpha;
      div_in[0].na        = s3_ff.na;
      div_in[0].quo       = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         num = {s3_ff.v[ch], 8'h00} - {8'h00, s3_ff.v[ch]};
         div_in[0].rem[ch] = num[15:8];
         div_in[0].low[ch] = num[7:0];
      end
      for (int s = 1; s <= DIV_STAGES; s++) begin
         div_in[s] = div_advance(div_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ga_ff    <= ALPHA_FULL;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_prev[k];
            end
         end
         if (csr_we) begin
            ga_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         s1_ff <= s1_in;
      end
      if (stage_ready[1]) begin
         s2_ff <= s2_in;
      end
      if (stage_ready[2]) begin
         s3_ff <= s3_in;
      end
      for (int s = 0; s <= DIV_STAGES; s++) begin
         if (stage_ready[3+s]) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   // response
   assign rsp_bus.valid     = valid_ff[NUM_STAGES-1];
   assign rsp_bus.out_red   = div_ff[DIV_STAGES].blend ? div_ff[DIV_STAGES].quo[0]
                                                       : div_ff[DIV_STAGES].byp_rgb[0];
   assign rsp_bus.out_green = div_ff[DIV_STAGES].blend ? div_ff[DIV_STAGES].quo[1]
                                                       : div_ff[DIV_STAGES].byp_rgb[1];
   assign rsp_bus.out_blue  = div_ff[DIV_STAGES].blend ? div_ff[DIV_STAGES].quo[2]
                                                       : div_ff[DIV_STAGES].byp_rgb[2];
   assign rsp_bus.out_alpha = div_ff[DIV_STAGES].blend ? div_ff[DIV_STAGES].na
                                                       : div_ff[DIV_STAGES].byp_alpha;

endmodule

### src/pab_checker.sv
// port-level checks of the alpha blender, bound to the top level
// depends on pab_pkg and pixel_alpha_over_blend
`timescale 1ns / 1ps

module pab_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pab_pkg::pix_type out_red,
   input pab_pkg::pix_type out_green,
   input pab_pkg::pix_type out_blue,
   input pab_pkg::pix_type out_alpha
);
   import pab_pkg::*;

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a free output slot propagates back to the request side
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled with free output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha))
      else $error("response payload changed while stalled");

endmodule

bind pixel_alpha_over_blend pab_checker u_pab_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_red   (rsp_bus.out_red),
   .out_green (rsp_bus.out_green),
   .out_blue  (rsp_bus.out_blue),
   .out_alpha (rsp_bus.out_alpha)
);

### tb/sv/testbench.sv
// self-checking testbench for pixel_alpha_over_blend: random idling on both channels,
// global alpha swept across its extremes, blended pixels checked against a local predictor
// depends on pab_pkg, the channel interfaces in pab_if.sv and the blender rtl
`timescale 1ns / 1ps

module testbench;
   import pab_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      rgb_type src;
      pix_type mask;
      rgb_type dst;
      pix_type dst_alpha;
   } pixel_req_type;

   typedef struct packed {
      rgb_type rgb;
      pix_type alpha;
   } blended_type;

   logic    clock;
   logic    reset;
   logic    csr_we;
   pix_type csr_wdata;

   pab_req_if req_bus ();
   pab_rsp_if rsp_bus ();

   pixel_alpha_over_blend DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   pixel_req_type pending_pixels[$];
   blended_type   blend_expect[$];
   pix_type       model_alpha;

   int   pixels_launched;
   int   pixels_taken;
   int   results_seen;
   int   results_handled;
   int   mismatches;
   int   alpha_settings;
   int   idle_cycles;
   int   send_gap;
   int   recv_stall;
   logic pixel_live;
   logic sender_calm;
   logic receiver_calm;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // round(a * b / 255)
   function automatic pix_type scale255(input pix_type a, input pix_type b);
      int t;
      t = a * b + 128;
      return pix_type'((t + (t >> 8)) >> 8);
   endfunction

   function automatic blended_type predict_over(input pixel_req_type p, input pix_type ga);
      blended_type r;
      pix_type     ea;
      pix_type     na;
      pix_type     v;
      int          q;
      r.rgb   = p.dst;
      r.alpha = p.dst_alpha;
      if (ga == 0)
         return r;
      ea = (ga != ALPHA_FULL && p.mask != 0) ? scale255(p.mask, ga) : p.mask;
      if (ea == ALPHA_FULL || p.dst_alpha == 0) begin
         r.rgb   = p.src;
         r.alpha = ea;
      end else if (ea != 0) begin
         na = ea + scale255(p.dst_alpha, ~ea);
         if (na == 0)
            na = 1;
         for (int c = 0; c < CHANNELS; c++) begin
            v = scale255(p.src[c], ea) + scale255(scale255(p.dst[c], p.dst_alpha), ~ea);
            q = (int'(v) * 255) / int'(na);
            r.rgb[c] = pix_type'(q);
         end
         r.alpha = na;
      end
      return r;
   endfunction

   function automatic pix_type pick_alpha();
      pix_type edges[4];
      edges = '{8'd0, 8'd1, 8'd254, 8'd255};
      if ($urandom_range(0, 3) == 0)
         return edges[2'($urandom_range(0, 3))];
      return pix_type'($urandom);
   endfunction

   task automatic add_pixel(input pix_type sr, input pix_type sg, input pix_type sb,
                            input pix_type m, input pix_type dr, input pix_type dg,
                            input pix_type db, input pix_type da);
      pixel_req_type p;
      p.src       = {sb, sg, sr};
      p.mask      = m;
      p.dst       = {db, dg, dr};
      p.dst_alpha = da;
      pending_pixels.push_back(p);
   endtask

   task automatic add_random(input int count);
      pixel_req_type p;
      for (int i = 0; i < count; i++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            p.src[c] = pix_type'($urandom);
            p.dst[c] = pix_type'($urandom);
         end
         p.mask      = pick_alpha();
         p.dst_alpha = pick_alpha();
         pending_pixels.push_back(p);
      end
   endtask

   task automatic wait_quiet();
      while (pending_pixels.size() != 0 || pixel_live || blend_expect.size() != 0)
         @(posedge clock);
   endtask

   // pipeline is empty here, so the write cannot overlap a transaction
   task automatic load_global_alpha(input pix_type value);
      wait_quiet();
      @(negedge clock);
      csr_we      <= 1'b1;
      csr_wdata   <= value;
      model_alpha  = value;
      @(negedge clock);
      csr_we <= 1'b0;
      alpha_settings++;
   endtask

   task automatic check_channel(input string name, input pix_type want, input pix_type got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      pixel_req_type nxt;
      logic          drive_valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
         pixel_live = 1'b0;
         send_gap   = 0;
      end else begin
         drive_valid = req_bus.valid;
         if (pixel_live && pixels_taken == pixels_launched) begin
            pixel_live = 1'b0;
            if ($urandom_range(0, 39) == 0)
               sender_calm = !sender_calm;
            send_gap    = sender_calm ? 0 : $urandom_range(0, 8);
            drive_valid = 1'b0;
         end
         if (!pixel_live) begin
            if (send_gap > 0) begin
               send_gap--;
               drive_valid = 1'b0;
            end else if (pending_pixels.size() != 0) begin
               nxt = pending_pixels.pop_front();
               req_bus.src_red    <= nxt.src[0];
               req_bus.src_green  <= nxt.src[1];
               req_bus.src_blue   <= nxt.src[2];
               req_bus.mask_alpha <= nxt.mask;
               req_bus.dst_red    <= nxt.dst[0];
               req_bus.dst_green  <= nxt.dst[1];
               req_bus.dst_blue   <= nxt.dst[2];
               req_bus.dst_alpha  <= nxt.dst_alpha;
               drive_valid = 1'b1;
               pixel_live  = 1'b1;
               pixels_launched++;
            end else begin
               drive_valid = 1'b0;
            end
         end
         req_bus.valid <= drive_valid;
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (results_seen != results_handled) begin
            results_handled = results_seen;
            if ($urandom_range(0, 39) == 0)
               receiver_calm = !receiver_calm;
            recv_stall = receiver_calm ? 0 : $urandom_range(0, 8);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // monitor: check responses, then record accepted requests
   always @(posedge clock) begin
      blended_type   got;
      blended_type   want;
      pixel_req_type seen;
      logic          progress;
      if (!reset) begin
         progress = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            progress  = 1'b1;
            got.rgb   = {rsp_bus.out_blue, rsp_bus.out_green, rsp_bus.out_red};
            got.alpha = rsp_bus.out_alpha;
            results_seen++;
            if (blend_expect.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got %p", $time, got);
               mismatches++;
            end else begin
               want = blend_expect.pop_front();
               check_channel("out_red",   want.rgb[0], got.rgb[0]);
               check_channel("out_green", want.rgb[1], got.rgb[1]);
               check_channel("out_blue",  want.rgb[2], got.rgb[2]);
               check_channel("out_alpha", want.alpha,  got.alpha);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            progress       = 1'b1;
            seen.src       = {req_bus.src_blue, req_bus.src_green, req_bus.src_red};
            seen.mask      = req_bus.mask_alpha;
            seen.dst       = {req_bus.dst_blue, req_bus.dst_green, req_bus.dst_red};
            seen.dst_alpha = req_bus.dst_alpha;
            blend_expect.push_back(predict_over(seen, model_alpha));
            pixels_taken++;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.src_red    = '0;
      req_bus.src_green  = '0;
      req_bus.src_blue   = '0;
      req_bus.mask_alpha = '0;
      req_bus.dst_red    = '0;
      req_bus.dst_green  = '0;
      req_bus.dst_blue   = '0;
      req_bus.dst_alpha  = '0;
      rsp_bus.ready      = 1'b0;
      model_alpha        = ALPHA_FULL;
      pixels_launched    = 0;
      pixels_taken       = 0;
      results_seen       = 0;
      results_handled    = 0;
      mismatches         = 0;
      alpha_settings     = 0;
      idle_cycles        = 0;
      send_gap           = 0;
      recv_stall         = 0;
      pixel_live         = 1'b0;
      sender_calm        = 1'b0;
      receiver_calm      = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      load_global_alpha(ALPHA_FULL);
      add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      // transparent mask, opaque mask, empty destination
      add_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd10, 8'd20, 8'd30, 8'd200);
      add_pixel(8'd12, 8'd34, 8'd56, 8'd255, 8'd200, 8'd100, 8'd50, 8'd128);
      add_pixel(8'd90, 8'd80, 8'd70, 8'd100, 8'd1, 8'd2, 8'd3, 8'd0);
      // general blend near the edges
      add_pixel(8'd255, 8'd0, 8'd128, 8'd128, 8'd0, 8'd255, 8'd64, 8'd255);
      add_pixel(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255);
      add_pixel(8'd0, 8'd0, 8'd0, 8'd254, 8'd255, 8'd255, 8'd255, 8'd1);
      add_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55);
      add_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA);
      add_pixel(8'd1, 8'd254, 8'd127, 8'd128, 8'd254, 8'd1, 8'd128, 8'd127);
      add_random(40);

      // zero global alpha keeps the destination
      load_global_alpha(8'd0);
      add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd7, 8'd8, 8'd9, 8'd10);
      add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
      add_random(40);

      // scaled mask rounds down to zero, full mask scales down to one
      load_global_alpha(8'd1);
      add_pixel(8'd100, 8'd100, 8'd100, 8'd1, 8'd5, 8'd5, 8'd5, 8'd50);
      add_pixel(8'd100, 8'd150, 8'd200, 8'd255, 8'd5, 8'd5, 8'd5, 8'd50);
      add_random(50);

      // full mask no longer opaque once scaled; small and zero masks as well
      load_global_alpha(8'd128);
      add_pixel(8'd200, 8'd100, 8'd50, 8'd255, 8'd50, 8'd100, 8'd200, 8'd255);
      add_pixel(8'd200, 8'd100, 8'd50, 8'd1, 8'd50, 8'd100, 8'd200, 8'd255);
      add_pixel(8'd200, 8'd100, 8'd50, 8'd0, 8'd50, 8'd100, 8'd200, 8'd77);
      add_random(70);

      for (int k = 0; k < 3; k++) begin
         load_global_alpha(pix_type'($urandom_range(2, 253)));
         add_random(60);
      end

      load_global_alpha(8'd254);
      add_random(70);
      load_global_alpha(ALPHA_FULL);
      add_random(90);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (blend_expect.size() != 0) begin
         $display("%0t: %0d expected transactions never arrived", $time, blend_expect.size());
         mismatches++;
      end
      $display("blended %0d pixels under %0d global alpha settings, both channels idling",
               results_seen, alpha_settings);
      $display("%0d field mismatches", mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### sim.f
src/pab_pkg.sv
src/pab_if.sv
src/pixel_alpha_over_blend.sv
src/pab_checker.sv
tb/sv/testbench.sv
